// ===== hw/rtl/srd_pkg.sv =====
`default_nettype none

package srd_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int MIN_MOVE_BITS  = 10;
	localparam int WINDOW_BITS    = 16;
	localparam int TALLY_BITS     = 4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DETECT_ENABLE    = 3'd0,
		REG_MIN_MOVE         = 3'd1,
		REG_WINDOW_LENGTH    = 3'd2,
		REG_REVERSALS_NEEDED = 3'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_LEFT  = 2'd2
	} dir_t;

	typedef struct packed {
		logic                     detect_enable;
		logic [MIN_MOVE_BITS-1:0] min_move;
		logic [WINDOW_BITS-1:0]   window_length;
		logic [TALLY_BITS-1:0]    reversals_needed;
	} srd_cfg_t;

	localparam logic [MIN_MOVE_BITS-1:0] MIN_MOVE_RESET  = 10'd10;
	localparam logic [WINDOW_BITS-1:0]   WINDOW_RESET    = 16'd1000;
	localparam logic [TALLY_BITS-1:0]    REVERSALS_RESET = 4'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/srd_cfg.sv =====
`default_nettype none

module srd_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [srd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [srd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output srd_pkg::srd_cfg_t                       cfg
);

	srd_pkg::srd_cfg_t cfg_q;
	logic              wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_enable    <= 1'b1;
			cfg_q.min_move         <= srd_pkg::MIN_MOVE_RESET;
			cfg_q.window_length    <= srd_pkg::WINDOW_RESET;
			cfg_q.reversals_needed <= srd_pkg::REVERSALS_RESET;
		end else if (wr) begin
			case (srd_pkg::reg_index_t'(cfg_index))
				srd_pkg::REG_DETECT_ENABLE: begin
					cfg_q.detect_enable <= cfg_data[0];
				end
				srd_pkg::REG_MIN_MOVE: begin
					cfg_q.min_move <= cfg_data[srd_pkg::MIN_MOVE_BITS-1:0];
				end
				srd_pkg::REG_WINDOW_LENGTH: begin
					cfg_q.window_length <= cfg_data[srd_pkg::WINDOW_BITS-1:0];
				end
				srd_pkg::REG_REVERSALS_NEEDED: begin
					cfg_q.reversals_needed <= cfg_data[srd_pkg::TALLY_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/srd_eval.sv =====
`default_nettype none

module srd_eval #(
	parameter int COORD_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire srd_pkg::srd_cfg_t            cfg,
	input  wire logic                         advance,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic [TIME_BITS-1:0]         time_ms,
	output logic                              shake
);

	localparam int MagBits = (COORD_BITS + 1 > srd_pkg::MIN_MOVE_BITS) ?
		COORD_BITS + 1 : srd_pkg::MIN_MOVE_BITS;

	logic signed [COORD_BITS-1:0]    prev_x_q;
	srd_pkg::dir_t                   prev_dir_q;
	logic [TIME_BITS-1:0]            window_begin_q;
	logic [srd_pkg::TALLY_BITS-1:0]  tally_q;

	logic signed [MagBits-1:0]       dx;
	logic [MagBits-1:0]              mag;
	logic                            moved;
	srd_pkg::dir_t                   dir;
	logic [TIME_BITS-1:0]            elapsed;
	logic                            expired;
	logic                            reversal;
	logic [srd_pkg::TALLY_BITS-1:0]  tally_inc;
	logic                            restart;
	logic                            take;

	// exact difference, wide enough that it never wraps
	assign dx    = MagBits'(pos_x) - MagBits'(prev_x_q);
	assign mag   = dx[MagBits-1] ? MagBits'(~dx + 1'b1) : MagBits'(dx);
	assign moved = cfg.detect_enable && (mag >= MagBits'(cfg.min_move));
	assign dir   = (!dx[MagBits-1] && (dx != '0)) ? srd_pkg::DIR_RIGHT : srd_pkg::DIR_LEFT;

	assign elapsed   = time_ms - window_begin_q;
	assign expired   = elapsed > TIME_BITS'(cfg.window_length);
	assign reversal  = (prev_dir_q != srd_pkg::DIR_NONE) && (dir != prev_dir_q);
	assign tally_inc = tally_q + 1'b1;

	assign shake   = moved && !expired && reversal && (tally_inc >= cfg.reversals_needed);
	assign restart = moved && (expired || shake);
	assign take    = advance && moved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q       <= '0;
			prev_dir_q     <= srd_pkg::DIR_NONE;
			window_begin_q <= '0;
			tally_q        <= '0;
		end else if (take) begin
			prev_x_q   <= pos_x;
			prev_dir_q <= dir;
			if (restart) begin
				window_begin_q <= time_ms;
				tally_q        <= '0;
			end else if (reversal) begin
				tally_q <= tally_inc;
			end
		end
	end

	a_shake_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && shake |=> tally_q == '0 && window_begin_q == $past(time_ms))
		else $error("shake did not restart the window");

	a_ignored_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !moved |=> $stable(prev_x_q) && $stable(tally_q) && $stable(window_begin_q))
		else $error("ignored move changed the state");

	a_flag_needs_move: assert property (@(posedge clk) disable iff (!arst_n)
		shake |-> cfg.detect_enable && prev_dir_q != srd_pkg::DIR_NONE)
		else $error("shake raised without an examined reversal");

endmodule

`default_nettype wire

// ===== hw/rtl/shake_reversal_detector_top.sv =====
// shake_reversal_detector_top
//
// Watches a stream of pointer moves (pos_x, time_ms) and flags a horizontal
// shake: enough direction reversals inside a time window. Each move word on
// the in channel (in_valid/in_ready) yields exactly one word on the out
// channel (out_valid/out_ready) carrying shake_seen.
// Moves are registered in the input register on acceptance, evaluated
// against the detector state once the output register is free, and the
// flag lands in the output register, which drives out_valid. One move is
// taken every cycle as long as the receiver keeps up; each move makes at
// most one state update.
// When out_ready is low the output register holds its word, the input
// register keeps one more move, and in_ready drops only once both are full.
// Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; write them only while no move is in flight. Indexes beyond the
// register list are ignored.
// Reset clears the detector state (no direction, zero window and tally) and
// loads the register defaults: enabled, min move 10, window 1000 ms,
// four reversals.

`default_nettype none

module shake_reversal_detector_top #(
	parameter int COORD_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [srd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [srd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [COORD_BITS-1:0]       pos_x,
	input  wire logic [TIME_BITS-1:0]               time_ms,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    shake_seen
);

	srd_pkg::srd_cfg_t            cfg;
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] pos_x_s1;
	logic [TIME_BITS-1:0]         time_ms_s1;
	logic                         out_valid_q;
	logic                         shake_q;
	logic                         shake;
	logic                         out_free;
	logic                         advance;

	srd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	srd_eval #(
		.COORD_BITS (COORD_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.pos_x   (pos_x_s1),
		.time_ms (time_ms_s1),
		.shake   (shake)
	);

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pos_x_s1   <= pos_x;
			time_ms_s1 <= time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			shake_q <= shake;
		end
	end

	assign out_valid  = out_valid_q;
	assign shake_seen = shake_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled with room in the pipeline");

	a_word_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("evaluated move lost before the output register");

	a_stalled_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shake_seen))
		else $error("stalled output word changed");

endmodule

`default_nettype wire

// ===== test/tb_shake_reversal_detector_top.sv =====
`timescale 1ns / 100ps

module tb_shake_reversal_detector_top;

	localparam int COORD_W     = 16;
	localparam int TIME_W      = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_MOVES = 120;

	localparam logic [srd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_FIRST =
		srd_pkg::REG_REVERSALS_NEEDED + 1;
	localparam logic [srd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LAST  =
		{srd_pkg::CFG_INDEX_BITS{1'b1}};

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic [TIME_W-1:0]         t;
	} move_t;

	typedef struct {
		logic [srd_pkg::CFG_INDEX_BITS-1:0] index;
		logic [srd_pkg::CFG_DATA_BITS-1:0]  data;
	} cfg_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [srd_pkg::CFG_INDEX_BITS-1:0] cfg_index = srd_pkg::REG_DETECT_ENABLE;
	logic [srd_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;
	logic                               in_valid  = 1'b0;
	logic                               in_ready;
	logic signed [COORD_W-1:0]          pos_x     = '0;
	logic [TIME_W-1:0]                  time_ms   = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               shake_seen;

	shake_reversal_detector_top #(
		.COORD_BITS(COORD_W),
		.TIME_BITS (TIME_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pos_x     (pos_x),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.shake_seen(shake_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	move_t     move_q[$];
	cfg_word_t cfg_q[$];
	bit        shake_expect_q[$];
	int        mismatches  = 0;
	int        results_seen = 0;
	int        cycle_count = 0;
	int        calm_left   = 0;

	// detector copy: registers and state after reset
	logic                              en_r       = 1'b1;
	logic [srd_pkg::MIN_MOVE_BITS-1:0] min_move_r = srd_pkg::MIN_MOVE_RESET;
	logic [srd_pkg::WINDOW_BITS-1:0]   window_r   = srd_pkg::WINDOW_RESET;
	logic [srd_pkg::TALLY_BITS-1:0]    needed_r   = srd_pkg::REVERSALS_RESET;
	logic signed [COORD_W-1:0]         last_x     = '0;
	srd_pkg::dir_t                     last_dir   = srd_pkg::DIR_NONE;
	logic [TIME_W-1:0]                 win_start  = '0;
	logic [srd_pkg::TALLY_BITS-1:0]    tally      = '0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic write_register(input logic [srd_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [srd_pkg::CFG_DATA_BITS-1:0] data);
		case (idx)
			srd_pkg::REG_DETECT_ENABLE:    en_r       = data[0];
			srd_pkg::REG_MIN_MOVE:         min_move_r = data[srd_pkg::MIN_MOVE_BITS-1:0];
			srd_pkg::REG_WINDOW_LENGTH:    window_r   = data[srd_pkg::WINDOW_BITS-1:0];
			srd_pkg::REG_REVERSALS_NEEDED: needed_r   = data[srd_pkg::TALLY_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic predict_shake(input logic signed [COORD_W-1:0] x,
			input logic [TIME_W-1:0] now);
		logic signed [COORD_W:0] dx;
		logic [COORD_W:0]        mag;
		logic [TIME_W-1:0]       elapsed;
		srd_pkg::dir_t           dir;
		bit                      flag;
		flag = 1'b0;
		if (en_r) begin
			// exact displacement, one bit wider than a coordinate
			dx  = {x[COORD_W-1], x} - {last_x[COORD_W-1], last_x};
			mag = dx[COORD_W] ? -dx : dx;
			if (mag >= {{(COORD_W+1-srd_pkg::MIN_MOVE_BITS){1'b0}}, min_move_r}) begin
				dir     = (!dx[COORD_W] && dx != 0) ? srd_pkg::DIR_RIGHT : srd_pkg::DIR_LEFT;
				elapsed = now - win_start;
				if (elapsed > {{(TIME_W-srd_pkg::WINDOW_BITS){1'b0}}, window_r}) begin
					tally     = '0;
					win_start = now;
				end else if (last_dir != srd_pkg::DIR_NONE && dir != last_dir) begin
					tally = tally + 1'b1;
					if (tally >= needed_r) begin
						tally     = '0;
						win_start = now;
						flag      = 1'b1;
					end
				end
				last_dir = dir;
				last_x   = x;
			end
		end
		shake_expect_q.push_back(flag);
	endtask

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_left = $urandom_range(40, 200);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin : drive_words
		move_t     mv;
		cfg_word_t cw;
		int        in_gap;
		if (!arst_n) begin
			in_gap = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (!cfg_valid || cfg_ready) begin
				if (cfg_q.size() != 0) begin
					cw = cfg_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= cw.index;
					cfg_data  <= cw.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end

			if (in_valid && in_ready)
				predict_shake(pos_x, time_ms);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (move_q.size() != 0) begin
					mv = move_q.pop_front();
					in_valid <= 1'b1;
					pos_x    <= mv.x;
					time_ms  <= mv.t;
					in_gap   = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_results
		int  out_stall;
		bit  want;
		if (!arst_n) begin
			out_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (shake_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %0d with no move pending", results_seen));
				end else begin
					want = shake_expect_q.pop_front();
					if (shake_seen !== want)
						report_mismatch($sformatf("result %0d: shake_seen %b, predicted %b",
							results_seen, shake_seen, want));
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, shake_expect_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic queue_move(input int x, input logic [TIME_W-1:0] t);
		move_t mv;
		mv.x = COORD_W'(x);
		mv.t = t;
		move_q.push_back(mv);
	endtask

	task automatic queue_cfg(input logic [srd_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [srd_pkg::CFG_DATA_BITS-1:0] data);
		cfg_word_t cw;
		cw.index = idx;
		cw.data  = data;
		cfg_q.push_back(cw);
	endtask

	// settle on falling edges so queue and valid updates of the rising edge are seen
	task automatic drain();
		while (move_q.size() != 0 || cfg_q.size() != 0 || in_valid || cfg_valid ||
				shake_expect_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int               ph, n, k, reps, r, step, next_x, side, jit;
		int               pointer_x;
		logic [TIME_W-1:0] clock_ms;
		int               mm, win, need;
		bit               en;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: a full shake, a small move, coordinate extremes, time wrap
		queue_move(20, 10);
		queue_move(25, 15);
		queue_move(0, 20);
		queue_move(20, 30);
		queue_move(0, 40);
		queue_move(20, 50);
		queue_move(32767, 60);
		queue_move(-32768, 70);
		queue_move(32767, 5000);
		queue_move(0, 32'hFFFF_FFF0);
		queue_move(100, 32'h0000_0100);
		drain();

		// zero displacement counts as leftward, zero reversals needed flags on the first reversal
		queue_cfg(srd_pkg::REG_MIN_MOVE, 16'hFC00);
		queue_cfg(srd_pkg::REG_REVERSALS_NEEDED, 16'hFFF0);
		queue_cfg(srd_pkg::REG_WINDOW_LENGTH, 16'hFFFF);
		queue_cfg(REG_SPARE_FIRST, 16'h0000);
		queue_cfg(REG_SPARE_LAST, 16'hFFFF);
		drain();
		queue_move(100, 32'h0000_0200);
		queue_move(100, 32'h0000_0210);
		queue_move(-1, 32'h0000_0220);
		drain();

		// zero window, widest min move
		queue_cfg(srd_pkg::REG_WINDOW_LENGTH, 16'h0000);
		queue_cfg(srd_pkg::REG_MIN_MOVE, 16'h03FF);
		queue_cfg(srd_pkg::REG_REVERSALS_NEEDED, 16'h000F);
		drain();
		queue_move(0, 7000);
		queue_move(2000, 7000);
		queue_move(0, 7000);
		queue_move(1000, 7000);
		queue_move(-2000, 7001);
		drain();

		// detection off, then back on
		queue_cfg(srd_pkg::REG_DETECT_ENABLE, 16'hFFFE);
		queue_cfg(srd_pkg::REG_MIN_MOVE, 16'h000A);
		queue_cfg(srd_pkg::REG_WINDOW_LENGTH, 16'hFFFF);
		drain();
		queue_move(20, 7100);
		queue_move(0, 7110);
		drain();
		queue_cfg(srd_pkg::REG_DETECT_ENABLE, 16'h0001);
		drain();

		// tally built up under a high threshold, then the threshold lowered
		queue_move(0, 200000);
		queue_move(50, 200001);
		queue_move(0, 200002);
		queue_move(50, 200003);
		queue_move(0, 200004);
		drain();
		queue_cfg(srd_pkg::REG_REVERSALS_NEEDED, 16'h0002);
		drain();
		queue_move(50, 200005);
		drain();

		pointer_x = 0;
		clock_ms  = 300000;
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0:       mm = 0;
				1:       mm = 1023;
				default: mm = $urandom_range(0, 40);
			endcase
			case ($urandom_range(0, 3))
				0:       win = 0;
				1:       win = 65535;
				default: win = $urandom_range(20, 3000);
			endcase
			case ($urandom_range(0, 3))
				0:       need = 1;
				1:       need = 15;
				default: need = $urandom_range(1, 8);
			endcase
			en = ($urandom_range(0, 9) != 0);
			queue_cfg(srd_pkg::REG_DETECT_ENABLE, {15'($urandom), en});
			queue_cfg(srd_pkg::REG_MIN_MOVE, {6'($urandom), 10'(mm)});
			queue_cfg(srd_pkg::REG_WINDOW_LENGTH, 16'(win));
			queue_cfg(srd_pkg::REG_REVERSALS_NEEDED, {12'($urandom), 4'(need)});
			if ($urandom_range(0, 2) == 0)
				queue_cfg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
			drain();

			n = 0;
			while (n < PHASE_MOVES) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					// back and forth swings with random amplitude and pace
					reps = $urandom_range(1, 18);
					side = ($urandom_range(0, 1) == 0) ? 1 : -1;
					for (k = 0; k < reps; k++) begin
						step   = mm + $urandom_range(0, 200);
						next_x = pointer_x + side * step;
						if (next_x > 32767 || next_x < -32768)
							next_x = pointer_x - side * step;
						pointer_x = next_x;
						side      = -side;
						r = $urandom_range(0, 99);
						if (r < 3)
							clock_ms = $urandom;
						else if (r < 5)
							clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
						else if (win != 0)
							clock_ms = clock_ms + $urandom_range(0, win / 6 + 1);
						queue_move(pointer_x, clock_ms);
						n++;
					end
				end else if (r < 90) begin
					// jitter below the minimum move
					jit = (mm > 0) ? $urandom_range(0, 2 * mm - 2) - (mm - 1) : 0;
					next_x = pointer_x + jit;
					if (next_x <= 32767 && next_x >= -32768)
						pointer_x = next_x;
					clock_ms = clock_ms + $urandom_range(0, 20);
					queue_move(pointer_x, clock_ms);
					n++;
				end else begin
					pointer_x = $signed(16'($urandom));
					clock_ms  = $urandom;
					queue_move(pointer_x, clock_ms);
					n++;
				end
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (shake_expect_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", shake_expect_q.size()));
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/srd_pkg.sv
hw/rtl/srd_cfg.sv
hw/rtl/srd_eval.sv
hw/rtl/shake_reversal_detector_top.sv
test/tb_shake_reversal_detector_top.sv
